/* design/lspg_pkg.sv */
// ----------------------------------------------------------------------------
// lspg_pkg
// Types and constants shared by the light spot pointer gesture block.
// ----------------------------------------------------------------------------
package lspg_pkg;

   // request: one camera frame
   typedef struct packed {
      logic [11:0] spot_x;
      logic [11:0] spot_y;
      logic        spot_present;
      logic [15:0] spot_area;
   } req_type;

   // response: one pointer event
   typedef struct packed {
      logic [2:0]  event_kind;
      logic [11:0] event_x;
      logic [11:0] event_y;
      logic        last_event;
   } rsp_type;

   typedef struct packed {
      logic [15:0] area_limit;
      logic [23:0] near_radius_sq;
      logic [7:0]  hold_frames;
   } cfg_type;

   // work handed from the classifier to the event sequencer
   typedef enum logic [1:0] {
      JOB_LEFT_DOWN,
      JOB_LEFT_UP,
      JOB_MOVE,
      JOB_CLICK_MOVE
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [11:0]  x;
      logic [11:0]  y;
   } job_type;

   localparam logic [2:0] EV_LEFT_DOWN  = 3'd0;
   localparam logic [2:0] EV_LEFT_UP    = 3'd1;
   localparam logic [2:0] EV_RIGHT_DOWN = 3'd2;
   localparam logic [2:0] EV_RIGHT_UP   = 3'd3;
   localparam logic [2:0] EV_MOVE       = 3'd4;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 24;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_AREA_LIMIT     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NEAR_RADIUS_SQ = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_FRAMES    = 2'd2;

   localparam logic [15:0] AREA_LIMIT_RESET     = 16'd1966;
   localparam logic [23:0] NEAR_RADIUS_SQ_RESET = 24'd100;
   localparam logic [7:0]  HOLD_FRAMES_RESET    = 8'd5;

   localparam logic [7:0] HOLD_COUNT_MAX = 8'hFF;

endpackage

/* design/light_spot_pointer_gestures.sv */
// ----------------------------------------------------------------------------
// light_spot_pointer_gestures
// Turns tracked light spot frames into left click, right click and move
// pointer events.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  lspg_pkg::req_type (one frame)
//   rsp_      out        rsp_valid/rsp_stall  lspg_pkg::rsp_type (one event)
//   csr_      in         csr_write_enable     csr_index, csr_write_data
//
// In the classifier, the first stage squares the offsets to the anchor and the
// second decides and updates the gesture state. A frame moves on to the second
// stage only once it is empty; requests stall while both stages are full.
// The sequencer sends one event per cycle unless the response is stalled, up
// to three per frame. Synchronous reset clears the control state and restores
// the register defaults; a stalled response holds while the queue takes jobs.
// ----------------------------------------------------------------------------
module light_spot_pointer_gestures #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lspg_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lspg_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [lspg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lspg_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic [15:0]       area_limit_ff, area_limit_in;
   logic [23:0]       near_radius_sq_ff, near_radius_sq_in;
   logic [7:0]        hold_frames_ff, hold_frames_in;
   lspg_pkg::cfg_type cfg;

   logic              push_valid, push_ready;
   lspg_pkg::job_type push_job;
   logic              pop_valid, pop_ready;
   lspg_pkg::job_type pop_job;

   always_comb begin
      area_limit_in     = area_limit_ff;
      near_radius_sq_in = near_radius_sq_ff;
      hold_frames_in    = hold_frames_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lspg_pkg::CSR_AREA_LIMIT: begin
               area_limit_in = csr_write_data[15:0];
            end
            lspg_pkg::CSR_NEAR_RADIUS_SQ: begin
               near_radius_sq_in = csr_write_data[23:0];
            end
            lspg_pkg::CSR_HOLD_FRAMES: begin
               hold_frames_in = csr_write_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_limit_ff     <= lspg_pkg::AREA_LIMIT_RESET;
         near_radius_sq_ff <= lspg_pkg::NEAR_RADIUS_SQ_RESET;
         hold_frames_ff    <= lspg_pkg::HOLD_FRAMES_RESET;
      end else begin
         area_limit_ff     <= area_limit_in;
         near_radius_sq_ff <= near_radius_sq_in;
         hold_frames_ff    <= hold_frames_in;
      end
   end

   assign cfg.area_limit     = area_limit_ff;
   assign cfg.near_radius_sq = near_radius_sq_ff;
   assign cfg.hold_frames    = hold_frames_ff;

   lspg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_job    (push_job),
      .push_ready  (push_ready)
   );

   lspg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   lspg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_job     (pop_job),
      .pop_ready   (pop_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

/* design/lspg_front.sv */
// ----------------------------------------------------------------------------
// lspg_front
// Takes frame requests, measures the distance to the anchor and classifies
// each frame into a gesture job for the event sequencer.
// ----------------------------------------------------------------------------
module lspg_front (
   input  logic              clock,
   input  logic              reset,
   input  lspg_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  lspg_pkg::req_type req_payload,
   output logic              push_valid,
   output lspg_pkg::job_type push_job,
   input  logic              push_ready
);

   // stage 1: captured frame
   logic              s1_valid_ff, s1_valid_in;
   lspg_pkg::req_type s1_req_ff;

   // stage 2: frame with squared offsets
   logic              s2_valid_ff, s2_valid_in;
   lspg_pkg::req_type s2_req_ff;
   logic              s2_small_ff;
   logic [23:0]       s2_sq_x_ff, s2_sq_y_ff;

   // gesture state
   logic              was_present_ff, was_present_in;
   logic [11:0]       anchor_x_ff, anchor_x_in;
   logic [11:0]       anchor_y_ff, anchor_y_in;
   logic [7:0]        hold_count_ff, hold_count_in;
   logic              blocked_ff, blocked_in;

   logic              req_accept;
   logic              s1_move;
   logic              s2_done;
   logic signed [12:0] dx, dy;
   logic signed [25:0] sq_x, sq_y;
   logic              s1_small;
   logic [24:0]       dist_sq;
   logic              near;
   logic [7:0]        hold_inc;
   logic [7:0]        hold_next;
   logic              press, release_evt, hold_evt;

   assign req_stall  = s1_valid_ff && s2_valid_ff;
   assign req_accept = req_valid && !req_stall;
   // stage 1 only moves on once the previous frame has updated the anchor
   assign s1_move    = s1_valid_ff && !s2_valid_ff;
   assign s2_done    = s2_valid_ff && push_ready;

   assign dx       = $signed({1'b0, s1_req_ff.spot_x} - {1'b0, anchor_x_ff});
   assign dy       = $signed({1'b0, s1_req_ff.spot_y} - {1'b0, anchor_y_ff});
   assign sq_x     = dx * dx;
   assign sq_y     = dy * dy;
   assign s1_small = s1_req_ff.spot_area < cfg.area_limit;

   assign dist_sq  = {1'b0, s2_sq_x_ff} + {1'b0, s2_sq_y_ff};
   assign near     = dist_sq < {1'b0, cfg.near_radius_sq};
   assign hold_inc = (hold_count_ff == lspg_pkg::HOLD_COUNT_MAX) ?
                     hold_count_ff : hold_count_ff + 8'd1;
   assign hold_next = near ? hold_inc : hold_count_ff;

   assign press       = s2_req_ff.spot_present && !was_present_ff && s2_small_ff;
   assign release_evt = !s2_req_ff.spot_present && was_present_ff && !blocked_ff;
   assign hold_evt    = s2_req_ff.spot_present && was_present_ff && s2_small_ff &&
                        !blocked_ff;

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s2_valid_in    = s2_valid_ff;
      was_present_in = was_present_ff;
      anchor_x_in    = anchor_x_ff;
      anchor_y_in    = anchor_y_ff;
      hold_count_in  = hold_count_ff;
      blocked_in     = blocked_ff;
      push_valid     = 1'b0;
      push_job.kind  = lspg_pkg::JOB_MOVE;
      push_job.x     = s2_req_ff.spot_x;
      push_job.y     = s2_req_ff.spot_y;

      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (s2_done) begin
         s2_valid_in = 1'b0;
      end

      if (s2_done) begin
         was_present_in = s2_req_ff.spot_present;
         if (press) begin
            hold_count_in = hold_inc;
            anchor_x_in   = s2_req_ff.spot_x;
            anchor_y_in   = s2_req_ff.spot_y;
            blocked_in    = 1'b0;
            push_valid    = 1'b1;
            push_job.kind = lspg_pkg::JOB_LEFT_DOWN;
         end else if (release_evt) begin
            hold_count_in = 8'd0;
            push_valid    = 1'b1;
            push_job.kind = lspg_pkg::JOB_LEFT_UP;
         end else if (hold_evt) begin
            push_valid = 1'b1;
            if (hold_next >= cfg.hold_frames) begin
               hold_count_in = 8'd0;
               blocked_in    = 1'b1;
               push_job.kind = lspg_pkg::JOB_CLICK_MOVE;
            end else begin
               hold_count_in = hold_next;
               push_job.kind = lspg_pkg::JOB_MOVE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         was_present_ff <= 1'b0;
         anchor_x_ff    <= 12'd0;
         anchor_y_ff    <= 12'd0;
         hold_count_ff  <= 8'd0;
         blocked_ff     <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         was_present_ff <= was_present_in;
         anchor_x_ff    <= anchor_x_in;
         anchor_y_ff    <= anchor_y_in;
         hold_count_ff  <= hold_count_in;
         blocked_ff     <= blocked_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_payload;
      end
      if (s1_move) begin
         s2_req_ff   <= s1_req_ff;
         s2_small_ff <= s1_small;
         s2_sq_x_ff  <= sq_x[23:0];
         s2_sq_y_ff  <= sq_y[23:0];
      end
   end

endmodule

/* design/lspg_queue.sv */
// ----------------------------------------------------------------------------
// lspg_queue
// Small job queue between the classifier and the event sequencer.
// ----------------------------------------------------------------------------
module lspg_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  lspg_pkg::job_type push_job,
   output logic              push_ready,
   output logic              pop_valid,
   output lspg_pkg::job_type pop_job,
   input  logic              pop_ready
);

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   lspg_pkg::job_type         slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      push_fire, pop_fire;

   assign push_ready = count_ff != COUNT_WIDTH'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* design/lspg_back.sv */
// ----------------------------------------------------------------------------
// lspg_back
// Expands each gesture job into one to three pointer events and holds them
// in the response register.
// ----------------------------------------------------------------------------
module lspg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  lspg_pkg::job_type pop_job,
   output logic              pop_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lspg_pkg::rsp_type rsp_payload
);

   logic              active_ff, active_in;
   lspg_pkg::job_type job_ff, job_in;
   logic [1:0]        step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lspg_pkg::rsp_type rsp_payload_ff, rsp_payload_in;

   lspg_pkg::rsp_type ev;
   logic              out_free;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // event for the current step of the job
   always_comb begin
      ev.event_x    = job_ff.x;
      ev.event_y    = job_ff.y;
      ev.event_kind = lspg_pkg::EV_MOVE;
      ev.last_event = 1'b1;
      case (job_ff.kind)
         lspg_pkg::JOB_LEFT_DOWN: begin
            ev.event_kind = lspg_pkg::EV_LEFT_DOWN;
         end
         lspg_pkg::JOB_LEFT_UP: begin
            ev.event_kind = lspg_pkg::EV_LEFT_UP;
         end
         lspg_pkg::JOB_CLICK_MOVE: begin
            case (step_ff)
               2'd0: begin
                  ev.event_kind = lspg_pkg::EV_RIGHT_DOWN;
                  ev.last_event = 1'b0;
               end
               2'd1: begin
                  ev.event_kind = lspg_pkg::EV_RIGHT_UP;
                  ev.last_event = 1'b0;
               end
               default: begin
                  ev.event_kind = lspg_pkg::EV_MOVE;
               end
            endcase
         end
         default: begin
            ev.event_kind = lspg_pkg::EV_MOVE;
         end
      endcase
   end

   assign pop_ready = !active_ff || (out_free && ev.last_event);

   always_comb begin
      active_in      = active_ff;
      job_in         = job_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (out_free) begin
         rsp_valid_in = active_ff;
         if (active_ff) begin
            rsp_payload_in = ev;
            if (ev.last_event) begin
               active_in = 1'b0;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
      end

      // next job loads as the last event of this one goes out
      if (pop_valid && pop_ready) begin
         active_in = 1'b1;
         job_in    = pop_job;
         step_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

/* design/lspg_checker.sv */
// ----------------------------------------------------------------------------
// lspg_checker
// Port level checks on the event stream of the gesture block.
// ----------------------------------------------------------------------------
module lspg_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lspg_pkg::rsp_type rsp_payload
);

   // no event straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // right-down always has right-up and move behind it
   a_right_down_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_kind == lspg_pkg::EV_RIGHT_DOWN
      |-> !rsp_payload.last_event)
      else $error("right-down flagged as last event");

   a_right_up_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_payload.event_kind == lspg_pkg::EV_RIGHT_DOWN
      |=> rsp_valid && rsp_payload.event_kind == lspg_pkg::EV_RIGHT_UP)
      else $error("right-up did not follow right-down");

   a_left_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.event_kind == lspg_pkg::EV_LEFT_DOWN ||
                    rsp_payload.event_kind == lspg_pkg::EV_LEFT_UP)
      |-> rsp_payload.last_event)
      else $error("left button event not last of its frame");

endmodule

bind light_spot_pointer_gestures lspg_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

/* dv/light_spot_pointer_gestures_tb.sv */
// ----------------------------------------------------------------------------
// light_spot_pointer_gestures_tb
// Self-checking bench for the light spot pointer gesture block. Camera frames
// go in through the request channel. A predictor of the gesture rules works
// out the pointer events for each accepted frame. Every event that comes out
// is compared, field by field, with the oldest prediction. Both sides stall
// at random, and the registers change between phases while the block is idle.
// ----------------------------------------------------------------------------
module light_spot_pointer_gestures_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lspg_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lspg_pkg::rsp_type rsp_payload;
   logic csr_write_enable = 1'b0;
   logic [lspg_pkg::CSR_INDEX_WIDTH-1:0] csr_index = lspg_pkg::CSR_AREA_LIMIT;
   logic [lspg_pkg::CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   // gesture state and registers as the predictor sees them
   lspg_pkg::cfg_type gesture_cfg;
   logic spot_was_present;
   logic [11:0] anchor_x;
   logic [11:0] anchor_y;
   logic [7:0] hold_count;
   logic events_blocked;

   lspg_pkg::rsp_type pending_events[$];
   int mismatch_count = 0;
   int checked_events = 0;
   logic idle_on = 1'b1;
   int stall_left = 0;

   light_spot_pointer_gestures dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   task automatic predict_frame_events(input lspg_pkg::req_type f);
      logic [2:0] kinds[$];
      logic spot_small;
      longint dx;
      longint dy;
      longint dist_sq;
      lspg_pkg::rsp_type ev;
      spot_small = f.spot_area < gesture_cfg.area_limit;
      if (f.spot_present && !spot_was_present && spot_small) begin
         if (hold_count != lspg_pkg::HOLD_COUNT_MAX) hold_count = hold_count + 8'd1;
         anchor_x = f.spot_x;
         anchor_y = f.spot_y;
         events_blocked = 1'b0;
         kinds.push_back(lspg_pkg::EV_LEFT_DOWN);
      end else if (!f.spot_present && spot_was_present && !events_blocked) begin
         kinds.push_back(lspg_pkg::EV_LEFT_UP);
         hold_count = 8'd0;
      end else if (f.spot_present && spot_was_present && spot_small && !events_blocked) begin
         dx = f.spot_x;
         dx = dx - anchor_x;
         dy = f.spot_y;
         dy = dy - anchor_y;
         dist_sq = dx * dx + dy * dy;
         if (dist_sq < gesture_cfg.near_radius_sq && hold_count != lspg_pkg::HOLD_COUNT_MAX)
            hold_count = hold_count + 8'd1;
         if (hold_count >= gesture_cfg.hold_frames) begin
            kinds.push_back(lspg_pkg::EV_RIGHT_DOWN);
            kinds.push_back(lspg_pkg::EV_RIGHT_UP);
            events_blocked = 1'b1;
            hold_count = 8'd0;
         end
         kinds.push_back(lspg_pkg::EV_MOVE);
      end
      spot_was_present = f.spot_present;
      foreach (kinds[i]) begin
         ev.event_kind = kinds[i];
         ev.event_x = f.spot_x;
         ev.event_y = f.spot_y;
         ev.last_event = (i == kinds.size() - 1);
         pending_events.push_back(ev);
      end
   endtask

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 100) $display("error at event %0d: %s", checked_events, what);
   endtask

   always @(posedge clock) begin : check_events
      lspg_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event kind %0d x %0d y %0d last %0d",
               rsp_payload.event_kind, rsp_payload.event_x, rsp_payload.event_y,
               rsp_payload.last_event));
         end else begin
            want = pending_events.pop_front();
            if (rsp_payload.event_kind !== want.event_kind)
               report_mismatch($sformatf("event_kind %0d, want %0d",
                  rsp_payload.event_kind, want.event_kind));
            if (rsp_payload.event_x !== want.event_x)
               report_mismatch($sformatf("event_x %0d, want %0d",
                  rsp_payload.event_x, want.event_x));
            if (rsp_payload.event_y !== want.event_y)
               report_mismatch($sformatf("event_y %0d, want %0d",
                  rsp_payload.event_y, want.event_y));
            if (rsp_payload.last_event !== want.last_event)
               report_mismatch($sformatf("last_event %0d, want %0d",
                  rsp_payload.last_event, want.last_event));
         end
         checked_events++;
      end
   end

   // response stalls come in random bursts, only while idle_on is set
   always @(posedge clock) begin
      if (!idle_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------
   task automatic send_frame(input lspg_pkg::req_type f);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_frame_events(f);
   endtask

   // drop valid, wait for every predicted event, then let silent frames drain
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_registers(input logic [15:0] area, input logic [23:0] radius,
                                input logic [7:0] hold);
      settle();
      csr_write_enable <= 1'b1;
      csr_index <= lspg_pkg::CSR_AREA_LIMIT;
      csr_write_data <= {8'd0, area};
      @(posedge clock);
      csr_index <= lspg_pkg::CSR_NEAR_RADIUS_SQ;
      csr_write_data <= radius;
      @(posedge clock);
      csr_index <= lspg_pkg::CSR_HOLD_FRAMES;
      csr_write_data <= {16'd0, hold};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      gesture_cfg.area_limit = area;
      gesture_cfg.near_radius_sq = radius;
      gesture_cfg.hold_frames = hold;
   endtask

   function automatic lspg_pkg::req_type make_frame(input int x, input int y,
                                                    input logic present, input int area);
      lspg_pkg::req_type f;
      f.spot_x = 12'(x);
      f.spot_y = 12'(y);
      f.spot_present = present;
      f.spot_area = 16'(area);
      return f;
   endfunction

   function automatic int near_coord(input int c, input int span);
      int v;
      v = c + $urandom_range(0, 2 * span) - span;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v;
   endfunction

   function automatic int small_area();
      if (gesture_cfg.area_limit == 16'd0) return $urandom_range(0, 65535);
      return $urandom_range(0, gesture_cfg.area_limit - 1);
   endfunction

   function automatic int large_area();
      return $urandom_range(gesture_cfg.area_limit, 65535);
   endfunction

   // mostly press / hold / release gestures, with noise and broken sequences
   task automatic run_gestures(input int n_frames, input int span);
      int sent;
      int ax;
      int ay;
      sent = 0;
      while (sent < n_frames) begin
         if ($urandom_range(0, 6) == 0) begin
            send_frame(make_frame($urandom_range(0, 4095), $urandom_range(0, 4095),
               1'($urandom_range(0, 1)), $urandom_range(0, 65535)));
            sent++;
         end else begin
            ax = $urandom_range(0, 4095);
            ay = $urandom_range(0, 4095);
            send_frame(make_frame(ax, ay, 1'b1, small_area()));
            sent++;
            repeat ($urandom_range(0, 10)) begin
               case ($urandom_range(0, 9))
                  0: send_frame(make_frame(near_coord(ax, span), near_coord(ay, span),
                        1'b1, large_area()));
                  1: send_frame(make_frame($urandom_range(0, 4095), $urandom_range(0, 4095),
                        1'b1, small_area()));
                  2: send_frame(make_frame($urandom_range(0, 4095), $urandom_range(0, 4095),
                        1'b0, $urandom_range(0, 65535)));
                  default: send_frame(make_frame(near_coord(ax, span), near_coord(ay, span),
                        1'b1, small_area()));
               endcase
               sent++;
            end
            send_frame(make_frame($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0,
               $urandom_range(0, 65535)));
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // reset register values: limit 1966, radius squared 100, hold 5
   task automatic test_directed_defaults();
      send_frame(make_frame(4095, 0, 1'b0, 65535));
      // large spot on appearance: present but no press
      send_frame(make_frame(100, 100, 1'b1, 1966));
      send_frame(make_frame(5, 7, 1'b0, 0));
      send_frame(make_frame(0, 0, 1'b1, 0));
      send_frame(make_frame(9, 0, 1'b1, 0));
      // distance squared exactly at the radius does not count
      send_frame(make_frame(6, 8, 1'b1, 100));
      send_frame(make_frame(0, 9, 1'b1, 1965));
      send_frame(make_frame(0, 0, 1'b1, 65535));
      send_frame(make_frame(4095, 4095, 1'b1, 0));
      send_frame(make_frame(1, 1, 1'b1, 0));
      send_frame(make_frame(0, 0, 1'b1, 0));
      send_frame(make_frame(2, 2, 1'b1, 0));
      // release after a right click stays silent
      send_frame(make_frame(3000, 3000, 1'b0, 0));
      send_frame(make_frame(4095, 4095, 1'b1, 1965));
      send_frame(make_frame(4095, 4086, 1'b1, 1));
      send_frame(make_frame(2048, 1024, 1'b0, 32768));
      send_frame(make_frame(0, 4095, 1'b0, 0));
      send_frame(make_frame(2000, 3000, 1'b1, 0));
      send_frame(make_frame(1234, 2345, 1'b0, 65535));
   endtask

   // hold count of zero clicks on the first hold frame after each press
   task automatic test_zero_hold_frames();
      set_registers(16'd1966, 24'd100, 8'd0);
      send_frame(make_frame(500, 600, 1'b1, 10));
      send_frame(make_frame(500, 600, 1'b1, 10));
      send_frame(make_frame(500, 600, 1'b1, 10));
      send_frame(make_frame(500, 600, 1'b0, 10));
      run_gestures(8, 10);
   endtask

   task automatic test_register_extremes();
      // nothing is small enough and nothing is near
      set_registers(16'd0, 24'd0, 8'd1);
      run_gestures(8, 4);
      // only the exact anchor counts as near
      set_registers(16'hFFFF, 24'd1, 8'd1);
      run_gestures(8, 1);
   endtask

   // every hold frame counts, so the count climbs to its ceiling
   task automatic test_hold_ceiling();
      int ax;
      int ay;
      set_registers(16'hFFFF, 24'hFFFFFF, 8'hFF);
      ax = $urandom_range(0, 2047);
      ay = $urandom_range(0, 2047);
      send_frame(make_frame(ax, ay, 1'b1, $urandom_range(0, 65534)));
      repeat (258)
         send_frame(make_frame($urandom_range(0, 2047), $urandom_range(0, 2047), 1'b1,
            $urandom_range(0, 65534)));
      send_frame(make_frame(ax, ay, 1'b0, 0));
   endtask

   task automatic test_random_gestures();
      set_registers(16'd3000, 24'd400, 8'd4);
      run_gestures(12, 20);
      set_registers(16'd1966, 24'd100, 8'd5);
      run_gestures(8, 10);
   endtask

   task automatic test_steady_stream();
      set_registers(16'd20000, 24'd2500, 8'd3);
      idle_on <= 1'b0;
      run_gestures(16, 50);
   endtask

   initial begin
      gesture_cfg.area_limit = lspg_pkg::AREA_LIMIT_RESET;
      gesture_cfg.near_radius_sq = lspg_pkg::NEAR_RADIUS_SQ_RESET;
      gesture_cfg.hold_frames = lspg_pkg::HOLD_FRAMES_RESET;
      spot_was_present = 1'b0;
      anchor_x = '0;
      anchor_y = '0;
      hold_count = '0;
      events_blocked = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_defaults();
      test_zero_hold_frames();
      test_register_extremes();
      test_hold_ceiling();
      test_random_gestures();
      test_steady_stream();
      settle();
      if (mismatch_count == 0) begin
         $display("light_spot_pointer_gestures: match");
      end else begin
         $display("light_spot_pointer_gestures: mismatch");
      end
      $finish;
   end

   initial begin
      #1600000;
      $display("light_spot_pointer_gestures: mismatch");
      $finish;
   end

endmodule

/* sim.f */
design/lspg_pkg.sv
design/lspg_front.sv
design/lspg_queue.sv
design/lspg_back.sv
design/light_spot_pointer_gestures.sv
design/lspg_checker.sv
dv/light_spot_pointer_gestures_tb.sv
